@@ src/bf_pkg.sv @@
package bf_pkg;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 64;

    localparam logic [CMD_W-1:0] CMD_SUBKEY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SBOX    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd2;

    localparam int SBOX_COUNT = 4;
    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [1:0] {
        OP_SUBKEY,
        OP_SBOX,
        OP_ENCRYPT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] table_index;
        logic [WORD_W-1:0]  table_word;
        logic [BLOCK_W-1:0] plain_block;
        logic               final_block;
    } t_item;

endpackage

@@ src/bf_stream_if.sv @@
interface bf_in_if;
    logic                        valid;
    logic                        ready;
    logic [bf_pkg::CMD_W-1:0]    command;
    logic [bf_pkg::INDEX_W-1:0]  table_index;
    logic [bf_pkg::WORD_W-1:0]   table_word;
    logic [bf_pkg::BLOCK_W-1:0]  plain_block;
    logic                        final_block;

    modport source (
        output valid, command, table_index, table_word, plain_block, final_block,
        input  ready
    );
    modport sink (
        input  valid, command, table_index, table_word, plain_block, final_block,
        output ready
    );
endinterface

interface bf_out_if;
    logic                        valid;
    logic                        ready;
    logic [bf_pkg::BLOCK_W-1:0]  cipher_block;
    logic                        final_out;

    modport source (
        output valid, cipher_block, final_out,
        input  ready
    );
    modport sink (
        input  valid, cipher_block, final_out,
        output ready
    );
endinterface

@@ src/bf_ram.sv @@
module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bf_front.sv @@
module bf_front #(
    parameter int ROUND_COUNT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bf_in_if.sink         i_cmd,
    output bf_pkg::t_item o_item,
    output logic          o_valid,
    input  logic          i_ready
);

    localparam logic [bf_pkg::INDEX_W-1:0] KeyLimit = bf_pkg::INDEX_W'(ROUND_COUNT + 2);

    logic          r_valid;
    logic          n_valid;
    bf_pkg::t_item r_item;
    bf_pkg::t_item n_item;
    logic          w_accept;
    logic          w_keep;

    assign i_cmd.ready = !r_valid || i_ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_item.table_index = i_cmd.table_index;
        n_item.table_word  = i_cmd.table_word;
        n_item.plain_block = i_cmd.plain_block;
        n_item.final_block = i_cmd.final_block;
        n_item.op          = bf_pkg::OP_ENCRYPT;
        w_keep             = 1'b0;
        unique case (i_cmd.command)
            bf_pkg::CMD_SUBKEY: begin
                n_item.op = bf_pkg::OP_SUBKEY;
                w_keep    = i_cmd.table_index < KeyLimit;
            end
            bf_pkg::CMD_SBOX: begin
                n_item.op = bf_pkg::OP_SBOX;
                w_keep    = 1'b1;
            end
            bf_pkg::CMD_ENCRYPT: begin
                n_item.op = bf_pkg::OP_ENCRYPT;
                w_keep    = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_ready;
        if (w_accept) begin
            n_valid = w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

@@ src/bf_fifo.sv @@
module bf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bf_pkg::t_item i_item,
    input  logic          i_valid,
    output logic          o_ready,
    output bf_pkg::t_item o_item,
    output logic          o_valid,
    input  logic          i_ready
);

    localparam int QAW = bf_pkg::QUEUE_AW;
    localparam logic [QAW:0] QDepth = (QAW + 1)'(bf_pkg::QUEUE_DEPTH);

    bf_pkg::t_item  r_mem [bf_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           w_push;
    logic           w_pop;

    assign o_ready = r_count != QDepth;
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QAW + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QAW + 1)'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QDepth)
        else $error("Queue holds more beats than it has entries.");
`endif

endmodule

@@ src/bf_core.sv @@
module bf_core #(
    parameter int ROUND_COUNT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bf_pkg::t_item i_q_item,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    bf_out_if.source      o_res
);

    localparam int KeyDepth = ROUND_COUNT + 2;
    localparam int KW       = $clog2(KeyDepth);
    localparam int RW       = $clog2(ROUND_COUNT);
    localparam logic [RW-1:0] LastRound = RW'(ROUND_COUNT - 1);
    localparam logic [KW-1:0] KeyRight  = KW'(ROUND_COUNT + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_x;
    logic [31:0] n_x;
    logic [31:0] r_y;
    logic [31:0] n_y;
    logic [RW-1:0] r_round;
    logic [RW-1:0] n_round;
    logic        r_final;
    logic        n_final;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_cipher;
    logic [63:0] n_cipher;
    logic        r_out_final;
    logic        n_out_final;
    logic [31:0] r_pkey [KeyDepth];

    logic [31:0] w_sdata [bf_pkg::SBOX_COUNT];
    logic [31:0] w_f;
    logic [31:0] w_mix;
    logic [31:0] w_start;
    logic [31:0] w_addr;
    logic        w_rd_en;
    logic        w_key_we;
    logic        w_sbox_wr;
    logic        w_out_free;

    assign w_f        = ((w_sdata[0] + w_sdata[1]) ^ w_sdata[2]) + w_sdata[3];
    assign w_mix      = r_y ^ w_f ^ r_pkey[KW'(r_round) + KW'(1)];
    assign w_start    = i_q_item.plain_block[63:32] ^ r_pkey[0];
    assign w_out_free = !r_out_valid || o_res.ready;
    assign o_q_ready  = r_state == S_IDLE;

    genvar g;
    generate
        for (g = 0; g < bf_pkg::SBOX_COUNT; g++) begin : g_sbox
            logic w_we;
            assign w_we = w_sbox_wr
                && (i_q_item.table_index[bf_pkg::INDEX_W-1:bf_pkg::SBOX_AW] == 2'(g));
            bf_ram #(
                .WIDTH (32),
                .DEPTH (bf_pkg::SBOX_DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we),
                .i_waddr (i_q_item.table_index[bf_pkg::SBOX_AW-1:0]),
                .i_wdata (i_q_item.table_word),
                .i_re    (w_rd_en),
                .i_raddr (w_addr[31 - 8 * g -: 8]),
                .o_rdata (w_sdata[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_round     = r_round;
        n_final     = r_final;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cipher    = r_cipher;
        n_out_final = r_out_final;
        w_rd_en     = 1'b0;
        w_addr      = w_mix;
        w_key_we    = 1'b0;
        w_sbox_wr   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        bf_pkg::OP_SUBKEY: begin
                            w_key_we = 1'b1;
                        end
                        bf_pkg::OP_SBOX: begin
                            w_sbox_wr = 1'b1;
                        end
                        bf_pkg::OP_ENCRYPT: begin
                            n_x     = w_start;
                            n_y     = i_q_item.plain_block[31:0];
                            n_round = '0;
                            n_final = i_q_item.final_block;
                            w_rd_en = 1'b1;
                            w_addr  = w_start;
                            n_state = S_RUN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (r_round != LastRound) begin
                    n_x     = w_mix;
                    n_y     = r_x;
                    n_round = r_round + RW'(1);
                    w_rd_en = 1'b1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_cipher    = {r_x ^ r_pkey[KeyRight], w_mix};
                    n_out_final = r_final;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_x         <= n_x;
        r_y         <= n_y;
        r_round     <= n_round;
        r_final     <= n_final;
        r_cipher    <= n_cipher;
        r_out_final <= n_out_final;
        if (w_key_we) begin
            r_pkey[i_q_item.table_index[KW-1:0]] <= i_q_item.table_word;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.cipher_block = r_cipher;
    assign o_res.final_out    = r_out_final;

`ifndef SYNTH
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_round <= LastRound)
        else $error("Round counter ran past the last round.");

    a_done_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && n_state == S_IDLE) |=> r_out_valid)
        else $error("Finished block did not reach the output register.");

    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sbox_wr || w_key_we) |-> r_state == S_IDLE)
        else $error("Table written while a block is being encrypted.");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_round == LastRound && !w_out_free) |=> r_state == S_RUN)
        else $error("Last round left while the output register was full.");
`endif

endmodule

@@ src/blowfish_block_encrypt_unit.sv @@
// Blowfish ECB encryption of 64-bit blocks with tables loaded by software.
// The input channel i_cmd carries one command per beat: a subkey word write,
// an S-box word write, or an encrypt of one plaintext block. The output
// channel o_res carries one ciphertext block per encrypt beat, in order,
// with final_out copied from final_block. Loads and unused commands give no
// output beat. Subkey writes with an index past the last subkey are dropped.
// Beats pass a front register and a two-entry queue before the engine, so
// the input takes beats while the engine is busy or stalled, until both fill.
// A load beat is written in the engine's idle state. An encrypt beat has an
// issue step there, then runs one round per cycle through the four S-box
// RAM read ports, holding its last round while the output register is full;
// the engine takes no new beat until the block is done. A plaintext beat
// passes the front register, queue, engine and output register in turn.
// When the receiver stalls, the engine holds its last round until the
// output register frees, then the queue and front register fill and i_cmd
// ready drops. Reset clears the control state only; the subkey and S-box
// contents are undefined until loaded.
module blowfish_block_encrypt_unit #(
    parameter int ROUND_COUNT = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bf_in_if.sink    i_cmd,
    bf_out_if.source o_res
);

    bf_pkg::t_item w_front_item;
    logic          w_front_valid;
    logic          w_front_ready;
    bf_pkg::t_item w_q_item;
    logic          w_q_valid;
    logic          w_q_ready;

    bf_front #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_item  (w_front_item),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready)
    );

    bf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_front_item),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready)
    );

    bf_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (w_q_item),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .o_res     (o_res)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int ROUNDS        = 16;
    localparam int SUBKEY_COUNT  = ROUNDS + 2;
    localparam int SUBKEY_AW     = $clog2(SUBKEY_COUNT);
    localparam int SBOX_ENTRIES  = bf_pkg::SBOX_COUNT * bf_pkg::SBOX_DEPTH;
    localparam int RANDOM_BEATS  = 400;
    localparam int TAIL_CYCLES   = 40;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 40;

    localparam logic [bf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [bf_pkg::CMD_W-1:0]   command;
        logic [bf_pkg::INDEX_W-1:0] table_index;
        logic [bf_pkg::WORD_W-1:0]  table_word;
        logic [bf_pkg::BLOCK_W-1:0] plain_block;
        logic                       final_block;
        bit                         drain_first;
    } t_cmd_beat;

    typedef struct {
        logic [bf_pkg::BLOCK_W-1:0] cipher_block;
        logic                       final_out;
    } t_cipher_beat;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bf_in_if  cmd_if ();
    bf_out_if res_if ();

    blowfish_block_encrypt_unit #(
        .ROUND_COUNT(ROUNDS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    logic [bf_pkg::WORD_W-1:0] subkey_mem [SUBKEY_COUNT];
    logic [bf_pkg::WORD_W-1:0] sbox_mem   [SBOX_ENTRIES];

    t_cmd_beat    pending_beats [$];
    t_cipher_beat cipher_expected [$];
    t_cmd_beat    in_flight;

    int       burst_left     = 0;
    int       gap_left       = 0;
    int       hold_left      = 0;
    bit       hold_done      = 1'b0;
    int       mode_left      = 0;
    t_rx_mode rx_mode        = RX_OPEN;
    int       results_seen   = 0;
    int       mismatch_count = 0;

    always #1 i_clk = ~i_clk;

    function automatic logic [bf_pkg::WORD_W-1:0] f_mix(
        input logic [bf_pkg::WORD_W-1:0] x
    );
        logic [bf_pkg::WORD_W-1:0] a, b, c, d;
        a = sbox_mem[{2'd0, x[31:24]}];
        b = sbox_mem[{2'd1, x[23:16]}];
        c = sbox_mem[{2'd2, x[15:8]}];
        d = sbox_mem[{2'd3, x[7:0]}];
        return ((a + b) ^ c) + d;
    endfunction

    function automatic logic [bf_pkg::BLOCK_W-1:0] encrypt_block(
        input logic [bf_pkg::BLOCK_W-1:0] plain
    );
        logic [bf_pkg::WORD_W-1:0] left, right;
        left  = plain[63:32];
        right = plain[31:0];
        for (int r = 0; r < ROUNDS; r++) begin
            if (r % 2 == 0) begin
                left  ^= subkey_mem[r];
                right ^= f_mix(left);
            end else begin
                right ^= subkey_mem[r];
                left  ^= f_mix(right);
            end
        end
        right ^= subkey_mem[ROUNDS + 1];
        left  ^= subkey_mem[ROUNDS];
        return {right, left};
    endfunction

    task automatic absorb_command(input t_cmd_beat beat);
        t_cipher_beat exp_beat;
        case (beat.command)
            bf_pkg::CMD_SUBKEY: begin
                if (beat.table_index < SUBKEY_COUNT)
                    subkey_mem[beat.table_index[SUBKEY_AW-1:0]] = beat.table_word;
            end
            bf_pkg::CMD_SBOX: begin
                sbox_mem[beat.table_index] = beat.table_word;
            end
            bf_pkg::CMD_ENCRYPT: begin
                exp_beat.cipher_block = encrypt_block(beat.plain_block);
                exp_beat.final_out    = beat.final_block;
                cipher_expected.push_back(exp_beat);
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_beat(input logic [bf_pkg::CMD_W-1:0] command,
                              input logic [bf_pkg::INDEX_W-1:0] table_index,
                              input logic [bf_pkg::WORD_W-1:0] table_word,
                              input logic [bf_pkg::BLOCK_W-1:0] plain_block,
                              input logic final_block,
                              input bit drain_first);
        t_cmd_beat beat;
        beat.command     = command;
        beat.table_index = table_index;
        beat.table_word  = table_word;
        beat.plain_block = plain_block;
        beat.final_block = final_block;
        beat.drain_first = drain_first;
        pending_beats.push_back(beat);
    endtask

    function automatic logic [bf_pkg::BLOCK_W-1:0] random_block();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [bf_pkg::INDEX_W-1:0] random_index();
        return bf_pkg::INDEX_W'($urandom_range(0, SBOX_ENTRIES - 1));
    endfunction

    // Sender: bursts of beats with random gaps, holding a beat until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_if.valid)
                absorb_command(in_flight);
            if (gap_left > 0) begin
                gap_left--;
                cmd_if.valid <= 1'b0;
            end else if (pending_beats.size() == 0 ||
                         (pending_beats[0].drain_first && cipher_expected.size() != 0)) begin
                cmd_if.valid <= 1'b0;
            end else begin
                in_flight = pending_beats.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.command     <= in_flight.command;
                cmd_if.table_index <= in_flight.table_index;
                cmd_if.table_word  <= in_flight.table_word;
                cmd_if.plain_block <= in_flight.plain_block;
                cmd_if.final_block <= in_flight.final_block;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                end
            end
        end
    end

    // Receiver: one long hold-off once the stream is running, otherwise a
    // pattern that moves between open, light and heavy stalling.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            res_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(32, 160);
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:  res_if.ready <= 1'b1;
                RX_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
                default:  res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_cipher_beat exp_beat;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (cipher_expected.size() == 0) begin
                if (mismatch_count < 10)
                    $display("Result beat %0d arrived with no block pending: cipher %h final %0b",
                             results_seen, res_if.cipher_block, res_if.final_out);
                mismatch_count++;
            end else begin
                exp_beat = cipher_expected.pop_front();
                if (res_if.cipher_block !== exp_beat.cipher_block ||
                    res_if.final_out !== exp_beat.final_out) begin
                    if (mismatch_count < 10)
                        $display("Result beat %0d: cipher exp %h got %h, final exp %0b got %0b",
                                 results_seen, exp_beat.cipher_block, res_if.cipher_block,
                                 exp_beat.final_out, res_if.final_out);
                    mismatch_count++;
                end
            end
            results_seen++;
        end
    end

    initial begin
        int pick;
        int placed;
        logic [bf_pkg::INDEX_W-1:0] idx;

        cmd_if.valid       = 1'b0;
        cmd_if.command     = bf_pkg::CMD_SUBKEY;
        cmd_if.table_index = '0;
        cmd_if.table_word  = '0;
        cmd_if.plain_block = '0;
        cmd_if.final_block = 1'b0;
        res_if.ready       = 1'b0;

        // Every table entry is loaded before the first encrypt reads it.
        for (int k = 0; k < SUBKEY_COUNT; k++)
            queue_beat(bf_pkg::CMD_SUBKEY, bf_pkg::INDEX_W'(k), $urandom, random_block(),
                       1'($urandom_range(0, 1)), 1'b0);
        for (int k = 0; k < SBOX_ENTRIES; k++)
            queue_beat(bf_pkg::CMD_SBOX, bf_pkg::INDEX_W'(k), $urandom, random_block(),
                       1'($urandom_range(0, 1)), 1'b0);

        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, '0, 1'b1, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, '1, 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, '1, '1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, '0, '0, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_SUBKEY, bf_pkg::INDEX_W'(SUBKEY_COUNT), '1, random_block(),
                   1'b1, 1'b0);
        queue_beat(bf_pkg::CMD_SUBKEY, '1, '0, random_block(), 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, random_block(), 1'b1, 1'b0);
        queue_beat(CMD_UNUSED, random_index(), $urandom, random_block(), 1'b1, 1'b0);
        queue_beat(CMD_UNUSED, '1, '1, '1, 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, random_block(), 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_SUBKEY, '0, '0, '1, 1'b1, 1'b0);
        queue_beat(bf_pkg::CMD_SUBKEY, bf_pkg::INDEX_W'(SUBKEY_COUNT - 1), '1, '0, 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_SBOX, '0, '1, random_block(), 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_SBOX, '1, '0, random_block(), 1'b1, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, '0, 1'b0, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, '1, 1'b1, 1'b0);
        queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, random_block(), 1'b1, 1'b1);

        placed = 0;
        while (placed < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                queue_beat(bf_pkg::CMD_ENCRYPT, random_index(), $urandom, random_block(),
                           $urandom_range(0, 3) == 0, placed % 100 == 99);
                placed++;
            end else if (pick < 83) begin
                queue_beat(bf_pkg::CMD_SUBKEY,
                           bf_pkg::INDEX_W'($urandom_range(0, SUBKEY_COUNT - 1)), $urandom,
                           random_block(), 1'($urandom_range(0, 1)), 1'b0);
                placed++;
            end else if (pick < 90) begin
                queue_beat(bf_pkg::CMD_SBOX, random_index(), $urandom, random_block(),
                           1'($urandom_range(0, 1)), 1'b0);
                placed++;
            end else if (pick < 95) begin
                idx = bf_pkg::INDEX_W'($urandom_range(SUBKEY_COUNT, SBOX_ENTRIES - 1));
                queue_beat(bf_pkg::CMD_SUBKEY, idx, $urandom, random_block(),
                           1'($urandom_range(0, 1)), 1'b0);
            end else begin
                queue_beat(CMD_UNUSED, random_index(), $urandom, random_block(),
                           1'($urandom_range(0, 1)), 1'b0);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || cmd_if.valid)
            @(posedge i_clk);
        while (cipher_expected.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
